// File: hdl/glbs_pkg.sv
package glbs_pkg;

   // Opcodes of a request transaction
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_MOVE   = 2'd2;
   localparam logic [1:0] OP_GET    = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] entry_value;
      logic [6:0]  move_count;
      logic        toward_end;
      logic [5:0]  position;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [6:0]  entry_count;
      logic [1:0]  status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;     // request transaction taken this cycle
      logic copy_step;  // one entry copied across the gap
      logic get_done;   // read data of a get is back
      logic move_done;  // last copy of a move
      logic rsp_load;   // load the result register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic long_get;   // current request is a get that reads the store
      logic long_move;  // current request is a move that copies entries
      logic copy_last;  // one copy left
   } dp_stat_type;

endpackage

// File: hdl/glbs_ctrl.sv
module glbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  glbs_pkg::dp_stat_type  stat,
   output glbs_pkg::ctrl_cmd_type cmd
);
   import glbs_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_GET  = 2'd1;
   localparam logic [1:0] S_MOVE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // Take a request only when idle and the result slot is free or draining
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Commands
   always_comb begin
      cmd.accept    = accept;
      cmd.copy_step = (state_ff == S_MOVE);
      cmd.move_done = (state_ff == S_MOVE) && stat.copy_last;
      cmd.get_done  = (state_ff == S_GET);
      cmd.rsp_load  = (accept && !stat.long_get && !stat.long_move)
                      || cmd.get_done || cmd.move_done;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && stat.long_move) begin
               state_in = S_MOVE;
            end else if (accept && stat.long_get) begin
               state_in = S_GET;
            end
         end
         S_GET: begin
            state_in = S_IDLE;
         end
         S_MOVE: begin
            if (stat.copy_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/glbs_dpath.sv
module glbs_dpath #(
   parameter int CAPACITY    = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  glbs_pkg::req_type      req_data,
   input  glbs_pkg::ctrl_cmd_type cmd,
   output glbs_pkg::dp_stat_type  stat,
   output glbs_pkg::rsp_type      rsp_data
);
   import glbs_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int CW = ((PW > 7) ? PW : 7) + 1;

   // Entry store: one write and one registered read per cycle
   logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
   logic [ENTRY_WIDTH-1:0] rdata_ff;
   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [ENTRY_WIDTH-1:0] wr_data;

   // Gap bounds and count
   logic [PW-1:0] first_ff, first_in;
   logic [PW-1:0] limit_ff, limit_in;
   logic [PW-1:0] total_ff, total_in;

   // Copy sequencer
   logic [AW-1:0] src_ff, src_in;
   logic [AW-1:0] dst_ff, dst_in;
   logic [PW-1:0] left_ff, left_in;
   logic          dir_ff, dir_in;
   logic [6:0]    mcount_ff, mcount_in;

   rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] first_w, limit_w, total_w, cap_w, count_w, pos_w, mcount_w;
   logic [CW-1:0] room_w, phys_w, src0_w, src1_w, dst0_w, total_in_w;
   logic          is_full, is_empty, move_bad, move_zero, get_range;
   logic [1:0]    st;
   logic [ENTRY_WIDTH-1:0] value_ew;
   logic [31:0]            rd32;

   // Entry width adaption on both sides
   generate
      if (ENTRY_WIDTH <= 32) begin : g_narrow_in
         assign value_ew = req_data.entry_value[ENTRY_WIDTH-1:0];
      end else begin : g_wide_in
         assign value_ew = {{(ENTRY_WIDTH-32){1'b0}}, req_data.entry_value};
      end
      if (ENTRY_WIDTH >= 32) begin : g_wide_out
         assign rd32 = rdata_ff[31:0];
      end else begin : g_narrow_out
         assign rd32 = {{(32-ENTRY_WIDTH){1'b0}}, rdata_ff};
      end
   endgenerate

   // Widened copies for compares
   assign first_w  = CW'(first_ff);
   assign limit_w  = CW'(limit_ff);
   assign total_w  = CW'(total_ff);
   assign cap_w    = CW'(CAPACITY);
   assign count_w  = CW'(req_data.move_count);
   assign pos_w    = CW'(req_data.position);
   assign mcount_w = CW'(mcount_ff);

   // Request checks
   assign is_full   = (first_ff >= limit_ff);
   assign is_empty  = (first_ff == '0);
   assign room_w    = cap_w - limit_w;
   assign move_bad  = req_data.toward_end ? (count_w > room_w) : (count_w > first_w);
   assign move_zero = (req_data.move_count == '0);
   assign get_range = (pos_w >= total_w);
   assign phys_w    = (pos_w < first_w) ? pos_w : (pos_w + limit_w - first_w);

   // First read and first destination of a move, and the source after it
   assign src0_w = req_data.toward_end ? limit_w : (first_w - CW'(1));
   assign src1_w = req_data.toward_end ? (limit_w + CW'(1)) : (first_w - CW'(2));
   assign dst0_w = req_data.toward_end ? first_w : (limit_w - CW'(1));

   always_comb begin
      stat.long_get  = (req_data.opcode == OP_GET) && !get_range;
      stat.long_move = (req_data.opcode == OP_MOVE) && !move_zero && !move_bad;
      stat.copy_last = (left_ff == PW'(1));
   end

   // Next values
   always_comb begin
      first_in  = first_ff;
      limit_in  = limit_ff;
      total_in  = total_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      left_in   = left_ff;
      dir_in    = dir_ff;
      mcount_in = mcount_ff;
      wr_en     = 1'b0;
      wr_addr   = dst_ff;
      wr_data   = rdata_ff;
      rd_en     = 1'b0;
      rd_addr   = src_ff;
      st        = ST_OK;

      if (cmd.accept) begin
         case (req_data.opcode)
            OP_INSERT: begin
               if (is_full) begin
                  st = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = first_w[AW-1:0];
                  wr_data  = value_ew;
                  first_in = first_ff + PW'(1);
                  total_in = total_ff + PW'(1);
               end
            end
            OP_DELETE: begin
               if (is_empty) begin
                  st = ST_EMPTY;
               end else begin
                  first_in = first_ff - PW'(1);
                  if (total_ff != '0) begin
                     total_in = total_ff - PW'(1);
                  end
               end
            end
            OP_MOVE: begin
               if (move_bad) begin
                  st = ST_RANGE;
               end else if (!move_zero) begin
                  rd_en     = 1'b1;
                  rd_addr   = src0_w[AW-1:0];
                  src_in    = src1_w[AW-1:0];
                  dst_in    = dst0_w[AW-1:0];
                  left_in   = count_w[PW-1:0];
                  dir_in    = req_data.toward_end;
                  mcount_in = req_data.move_count;
               end
            end
            OP_GET: begin
               if (get_range) begin
                  st = ST_RANGE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = phys_w[AW-1:0];
               end
            end
            default: begin
               st = ST_OK;
            end
         endcase
      end

      // One entry across the gap per cycle, next read overlapped
      if (cmd.copy_step) begin
         wr_en   = 1'b1;
         wr_addr = dst_ff;
         wr_data = rdata_ff;
         dst_in  = dir_ff ? (dst_ff + AW'(1)) : (dst_ff - AW'(1));
         left_in = left_ff - PW'(1);
         if (!stat.copy_last) begin
            rd_en   = 1'b1;
            rd_addr = src_ff;
            src_in  = dir_ff ? (src_ff + AW'(1)) : (src_ff - AW'(1));
         end
      end

      // Shift both gap bounds when the move completes
      if (cmd.move_done) begin
         first_in = dir_ff ? PW'(first_w + mcount_w) : PW'(first_w - mcount_w);
         limit_in = dir_ff ? PW'(limit_w + mcount_w) : PW'(limit_w - mcount_w);
      end
   end

   // Result register
   assign total_in_w = CW'(total_in);

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.read_value  = cmd.get_done ? rd32 : 32'd0;
         rsp_in.entry_count = total_in_w[6:0];
         rsp_in.status      = st;
      end
   end

   assign rsp_data = rsp_ff;

   // Store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         limit_ff <= PW'(CAPACITY);
         total_ff <= '0;
         left_ff  <= '0;
      end else begin
         first_ff <= first_in;
         limit_ff <= limit_in;
         total_ff <= total_in;
         left_ff  <= left_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      src_ff    <= src_in;
      dst_ff    <= dst_in;
      dir_ff    <= dir_in;
      mcount_ff <= mcount_in;
      rsp_ff    <= rsp_in;
   end

endmodule

// File: hdl/gap_buffer_line_store_top.sv
// Gap buffer of CAPACITY entry handles with insert, delete, gap move and get.
// Each request transaction yields one response transaction, held in an output
// register. Insert, delete, a zero-count move and any rejected request finish in
// the cycle they are accepted; a get waits on one registered read of the entry
// store; a move copies one entry per cycle across the gap, since the store has
// one write and one read port. A new request is taken once the controller is
// idle and the output register is empty or being emptied.
module gap_buffer_line_store_top #(
   parameter int CAPACITY    = 64,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  glbs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output glbs_pkg::rsp_type rsp_data
);
   import glbs_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   glbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   glbs_dpath #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // A pending, unaccepted result blocks new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while result pending");

   // Requests that finish at once present their result next cycle
   a_short_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !stat.long_get && !stat.long_move) |=> rsp_valid)
      else $error("short request produced no result");

   // A get that reads the store signals get_done, then presents its registered result
   a_get_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && stat.long_get) |=> cmd.get_done ##1 rsp_valid)
      else $error("get result late");
`endif

endmodule

// File: tb/gap_buffer_line_store_top_tb.sv
module gap_buffer_line_store_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import glbs_pkg::*;

   localparam int CAPACITY = 64;

   // Tracks the gap buffer contents and owes one response per request transaction
   class gap_tracker;
      logic [31:0] slots [CAPACITY];
      int unsigned gap_first;
      int unsigned gap_limit;
      int unsigned total;
      rsp_type     owed [$];
      int          errors;

      function new();
         foreach (slots[i]) slots[i] = '0;
         gap_first = 0;
         gap_limit = CAPACITY;
         total     = 0;
         errors    = 0;
      endfunction

      task report(string what);
         errors++;
         $display("%0t mismatch: %s", $realtime, what);
      endtask

      // Update the buffer for an accepted request and queue its response
      function void apply_request(req_type item);
         rsp_type     rsp;
         int unsigned cnt;
         int unsigned phys;
         rsp.read_value = '0;
         rsp.status     = ST_OK;
         cnt = item.move_count;
         case (item.opcode)
            OP_INSERT: begin
               if (gap_first >= gap_limit) begin
                  rsp.status = ST_FULL;
               end else begin
                  slots[gap_first] = item.entry_value;
                  gap_first++;
                  total++;
               end
            end
            OP_DELETE: begin
               if (gap_first == 0) begin
                  rsp.status = ST_EMPTY;
               end else begin
                  gap_first--;
                  if (total > 0) total--;
               end
            end
            OP_MOVE: begin
               if (item.toward_end) begin
                  if (cnt > CAPACITY - gap_limit) begin
                     rsp.status = ST_RANGE;
                  end else begin
                     // destination below source: ascending copy
                     for (int i = 0; i < cnt; i++)
                        slots[gap_first + i] = slots[gap_limit + i];
                     gap_first += cnt;
                     gap_limit += cnt;
                  end
               end else begin
                  if (cnt > gap_first) begin
                     rsp.status = ST_RANGE;
                  end else begin
                     // destination above source: descending copy
                     for (int i = cnt; i > 0; i--)
                        slots[gap_limit - cnt + i - 1] = slots[gap_first - cnt + i - 1];
                     gap_first -= cnt;
                     gap_limit -= cnt;
                  end
               end
            end
            default: begin
               if (item.position >= total) begin
                  rsp.status = ST_RANGE;
               end else begin
                  phys = (item.position < gap_first) ? item.position
                                                     : item.position + gap_limit - gap_first;
                  if (phys < CAPACITY) rsp.read_value = slots[phys];
                  else rsp.status = ST_RANGE;
               end
            end
         endcase
         rsp.entry_count = 7'(total);
         owed.push_back(rsp);
      endfunction

      task check_response(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            report($sformatf("response with none outstanding: %h", got));
         end else begin
            want = owed.pop_front();
            if (got.read_value !== want.read_value)
               report($sformatf("read_value %h, want %h", got.read_value, want.read_value));
            if (got.entry_count !== want.entry_count)
               report($sformatf("entry_count %0d, want %0d",
                                got.entry_count, want.entry_count));
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
         end
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   gap_tracker sb = new();

   gap_buffer_line_store_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   function automatic req_type make_req(logic [1:0] op, logic [31:0] value,
                                        logic [6:0] cnt, logic to_end, logic [5:0] pos);
      req_type item;
      item.opcode      = op;
      item.entry_value = value;
      item.move_count  = cnt;
      item.toward_end  = to_end;
      item.position    = pos;
      return item;
   endfunction

   // Mostly legal moves and in-range gets; the rest is random noise
   function automatic req_type random_request(int insert_pct);
      req_type     item;
      int unsigned reach;
      item.entry_value = $urandom();
      item.move_count  = 7'($urandom_range(CAPACITY));
      item.toward_end  = 1'($urandom_range(1));
      item.position    = 6'($urandom_range(63));
      if ($urandom_range(99) < insert_pct) begin
         item.opcode = OP_INSERT;
      end else begin
         case ($urandom_range(9))
            0, 1:          item.opcode = OP_DELETE;
            2, 3, 4, 5:    item.opcode = OP_MOVE;
            default:       item.opcode = OP_GET;
         endcase
      end
      if (item.opcode == OP_MOVE && $urandom_range(99) < 85) begin
         reach = item.toward_end ? CAPACITY - sb.gap_limit : sb.gap_first;
         // keep most moves short, since a move stalls new requests while it copies
         if ($urandom_range(99) < 80 && reach > 6) reach = 6;
         item.move_count = 7'($urandom_range(reach));
      end
      if (item.opcode == OP_GET && sb.total > 0 && $urandom_range(99) < 85)
         item.position = 6'($urandom_range(sb.total - 1));
      return item;
   endfunction

   // valid is only lowered while idling, so back-to-back transactions keep it high
   task automatic send_req(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.apply_request(item);
   endtask

   task automatic run_phase(int idle, int stall, int insert_pct, int n);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      repeat (n) send_req(random_request(insert_pct));
   endtask

   task automatic wait_drained();
      while (sb.owed.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-buffer corner cases, extremes, moves across the gap
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_DELETE, 32'h0,          7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_MOVE,   32'h0,          7'd0,  1'b1, 6'd0));
      send_req(make_req(OP_MOVE,   32'h0,          7'd1,  1'b1, 6'd0));
      send_req(make_req(OP_MOVE,   32'h0,          7'd1,  1'b0, 6'd0));
      send_req(make_req(OP_INSERT, 32'h0000_0000,  7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_INSERT, 32'hFFFF_FFFF,  7'd127 & 7'd64, 1'b1, 6'd63));
      send_req(make_req(OP_INSERT, 32'hA5A5_5A5A,  7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_INSERT, 32'h5A5A_A5A5,  7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_MOVE,   32'h0,          7'd2,  1'b0, 6'd0));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd1));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd2));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd3));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd63));
      send_req(make_req(OP_MOVE,   32'h0,          7'd3,  1'b1, 6'd0));
      send_req(make_req(OP_MOVE,   32'h0,          7'd2,  1'b1, 6'd0));
      send_req(make_req(OP_DELETE, 32'h0,          7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_MOVE,   32'h0,          7'd64, 1'b0, 6'd0));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd3));
      send_req(make_req(OP_INSERT, 32'h8000_0001,  7'd64, 1'b1, 6'd63));
      send_req(make_req(OP_MOVE,   32'h0,          7'd4,  1'b0, 6'd0));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd0));
      send_req(make_req(OP_GET,    32'h0,          7'd0,  1'b0, 6'd3));

      // Random phases; insert bias swings the fill between empty and full
      run_phase(0,  0,  50, 300);
      run_phase(58, 0,  70, 300);
      req_valid <= 1'b0;
      wait_drained();
      run_phase(0,  58, 10, 300);
      run_phase(19, 19, 50, 300);
      run_phase(0,  0,  60, 300);

      req_valid <= 1'b0;
      wait_drained();
      // leave time for the longest move to finish
      repeat (80) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[gap_buffer_line_store_top] OK");
      end else begin
         $display("[gap_buffer_line_store_top] ERROR");
      end
      $finish;
   end

   // Run watchdog
   initial begin
      #3ms;
      $display("[gap_buffer_line_store_top] ERROR");
      $finish;
   end

endmodule

// File: sim.f
hdl/glbs_pkg.sv
hdl/glbs_ctrl.sv
hdl/glbs_dpath.sv
hdl/gap_buffer_line_store_top.sv
tb/gap_buffer_line_store_top_tb.sv
